>>> rtl/core/i2c_eeprom_byte_access_master_macros.svh
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: assertion macros
// Concurrent assertion wrappers used by the bit sequencer.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_MACROS_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge outside reset
`define I2CM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("i2cm assertion failed");

// Check that a condition never occurs outside reset
`define I2CM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("i2cm forbidden condition seen");

`else

`define I2CM_ASSERT(lbl, clk, rstn, prop)
`define I2CM_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: package
// Shared types and constants of the tick queue, sequencer and top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Tick queue depth between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_BIT    = 2'd0,
    CFG_ACK_TIMEOUT = 2'd1,
    CFG_WRITE_CYCLE = 2'd2,
    CFG_DEVICE_ADDR = 2'd3
  } cfg_reg_e;

  // Register reset values
  localparam logic [15:0] HalfBitReset    = 16'd5;
  localparam logic [15:0] AckTimeoutReset = 16'd500;
  localparam logic [23:0] WriteCycleReset = 24'd10000;
  localparam logic [6:0]  DeviceAddrReset = 7'd80;

  // Wait count marker that flags an ACK timeout
  localparam logic [15:0] TimeoutMark = 16'hFFFF;

  // One tick word as it travels from front to back
  typedef struct packed {
    logic       request;
    logic       func;
    logic [7:0] mem_address;
    logic [7:0] write_data;
    logic       sda_sample;
  } item_t;

  // Configuration register set
  typedef struct packed {
    logic [15:0] half_bit_ticks;
    logic [15:0] ack_timeout_ticks;
    logic [23:0] write_cycle_ticks;
    logic [6:0]  device_address;
  } cfg_t;

  // Handshake between queue and sequencer
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

>>> rtl/core/i2cm_front.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: front tick queue
// Accepts tick words, packs the fields and buffers them for the sequencer.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                request_i,
  input  logic                func_i,
  input  logic [7:0]          mem_address_i,
  input  logic [7:0]          write_data_i,
  input  logic                sda_sample_i,
  output i2cm_pkg::head_t     head_o,
  input  logic                pop_i
);

  localparam int unsigned Depth = i2cm_pkg::QueueDepth;
  localparam int unsigned PtrW  = i2cm_pkg::QueuePtrW;
  localparam int unsigned CntW  = i2cm_pkg::QueueCntW;

  i2cm_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  i2cm_pkg::item_t item_in;
  logic            push;
  logic            pop;

  // Pack the incoming word
  assign item_in = '{request:     request_i,
                     func:        func_i,
                     mem_address: mem_address_i,
                     write_data:  write_data_i,
                     sda_sample:  sda_sample_i};

  // Stall only when every slot holds a word
  assign in_stall_o = (count_q == CntW'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != '0);

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the word in its slot
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

>>> rtl/core/i2cm_seq.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: bit sequencer
// Runs the START/byte/ACK/STOP sequence one tick per word, with output register.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_byte_access_master_macros.svh"

module i2cm_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  i2cm_pkg::cfg_t  cfg_i,
  input  i2cm_pkg::head_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            scl_level_o,
  output logic            sda_level_o,
  output logic            sda_drive_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic [7:0]      read_byte_o
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_STA, PH_STB,
    PH_TXL, PH_TXH, PH_AKL, PH_AKH,
    PH_RSL, PH_RSA, PH_RSB,
    PH_RXL, PH_RXH, PH_NKL, PH_NKH,
    PH_SPL, PH_SPA, PH_SPB, PH_HOLD
  } phase_e;

  typedef enum logic [1:0] {
    STG_DEV_W, STG_MEM, STG_DATA, STG_DEV_R
  } stage_e;

  phase_e      phase_q, phase_d, phase_c;
  stage_e      stage_q, stage_d;
  logic [3:0]  bit_q, bit_d, bit_inc;
  logic [7:0]  shift_q, shift_d, shift_rx;
  logic [23:0] tick_q, tick_d, tick_c, tick_step;
  logic [24:0] tick_inc;
  logic [15:0] ack_q, ack_d, ack_c;
  logic        kind_q, kind_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic [7:0]  last_q, last_d;
  logic [15:0] half_len;
  logic        half_end, hold_end, start;
  logic        scl, sda, drv, done, busy;
  logic        out_valid_q;
  logic        scl_q, sda_q, drv_q, busy_q, done_q;
  logic        pop;
  i2cm_pkg::item_t item;

  // Byte sent at the start of each stage
  function automatic logic [7:0] stage_byte(stage_e s, logic [6:0] dev,
                                            logic [7:0] a, logic [7:0] d);
    logic [7:0] b;
    case (s)
      STG_DEV_W: b = {dev, 1'b0};
      STG_MEM:   b = a;
      STG_DATA:  b = d;
      default:   b = {dev, 1'b1};
    endcase
    return b;
  endfunction

  assign item = head_i.item;
  assign pop  = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = pop;

  // Take a request while idle as the first START tick
  assign start   = (phase_q == PH_IDLE) && item.request;
  assign phase_c = start ? PH_STA : phase_q;
  assign tick_c  = start ? '0 : tick_q;
  assign ack_c   = start ? '0 : ack_q;
  assign kind_d  = start ? item.func : kind_q;
  assign addr_d  = start ? item.mem_address : addr_q;
  assign data_d  = start ? item.write_data : data_q;

  // Step timer
  assign half_len  = (cfg_i.half_bit_ticks == '0) ? 16'd1 : cfg_i.half_bit_ticks;
  assign tick_inc  = {1'b0, tick_c} + 25'd1;
  assign half_end  = (tick_inc >= {9'b0, half_len});
  assign hold_end  = (tick_inc >= {1'b0, cfg_i.write_cycle_ticks});
  assign tick_step = half_end ? '0 : tick_inc[23:0];
  assign bit_inc   = bit_q + 4'd1;
  assign shift_rx  = {shift_q[6:0], item.sda_sample};

  // Next state and line levels for this tick
  always_comb begin
    phase_d = phase_c;
    stage_d = stage_q;
    tick_d  = tick_c;
    ack_d   = ack_c;
    bit_d   = bit_q;
    shift_d = shift_q;
    last_d  = last_q;
    scl     = 1'b1;
    sda     = 1'b1;
    drv     = 1'b1;
    done    = 1'b0;
    unique case (phase_c)
      PH_IDLE: begin
        tick_d = tick_c;
      end
      PH_STA: begin
        tick_d = tick_step;
        if (half_end) phase_d = PH_STB;
      end
      PH_STB: begin
        sda    = 1'b0;
        tick_d = tick_step;
        if (half_end) begin
          shift_d = stage_byte(STG_DEV_W, cfg_i.device_address, addr_d, data_d);
          stage_d = STG_DEV_W;
          bit_d   = '0;
          phase_d = PH_TXL;
        end
      end
      PH_TXL: begin
        scl    = 1'b0;
        sda    = shift_q[7];
        tick_d = tick_step;
        if (half_end) phase_d = PH_TXH;
      end
      PH_TXH: begin
        sda    = shift_q[7];
        tick_d = tick_step;
        if (half_end) begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_inc;
          if (bit_inc >= 4'd8) begin
            bit_d   = '0;
            ack_d   = '0;
            phase_d = PH_AKL;
          end else begin
            phase_d = PH_TXL;
          end
        end
      end
      PH_AKL: begin
        scl    = 1'b0;
        drv    = 1'b0;
        tick_d = tick_step;
        if (half_end) phase_d = PH_AKH;
      end
      PH_AKH: begin
        drv = 1'b0;
        if (!half_end) begin
          tick_d = tick_inc[23:0];
        end else if (!item.sda_sample) begin
          // Slave acknowledged: move to the next stage
          ack_d  = '0;
          tick_d = '0;
          case (stage_q)
            STG_DEV_W: begin
              shift_d = stage_byte(STG_MEM, cfg_i.device_address, addr_d, data_d);
              stage_d = STG_MEM;
              bit_d   = '0;
              phase_d = PH_TXL;
            end
            STG_MEM: begin
              if (kind_d) begin
                phase_d = PH_RSL;
              end else begin
                shift_d = stage_byte(STG_DATA, cfg_i.device_address, addr_d, data_d);
                stage_d = STG_DATA;
                bit_d   = '0;
                phase_d = PH_TXL;
              end
            end
            STG_DATA: phase_d = PH_SPL;
            default: begin
              bit_d   = '0;
              phase_d = PH_RXL;
            end
          endcase
        end else if (ack_c >= cfg_i.ack_timeout_ticks) begin
          // Give up: send STOP and restart the transaction
          ack_d   = i2cm_pkg::TimeoutMark;
          tick_d  = '0;
          phase_d = PH_SPL;
        end else begin
          ack_d = ack_c + 16'd1;
        end
      end
      PH_RSL: begin
        scl    = 1'b0;
        tick_d = tick_step;
        if (half_end) phase_d = PH_RSA;
      end
      PH_RSA: begin
        tick_d = tick_step;
        if (half_end) phase_d = PH_RSB;
      end
      PH_RSB: begin
        sda    = 1'b0;
        tick_d = tick_step;
        if (half_end) begin
          shift_d = stage_byte(STG_DEV_R, cfg_i.device_address, addr_d, data_d);
          stage_d = STG_DEV_R;
          bit_d   = '0;
          phase_d = PH_TXL;
        end
      end
      PH_RXL: begin
        scl    = 1'b0;
        drv    = 1'b0;
        tick_d = tick_step;
        if (half_end) phase_d = PH_RXH;
      end
      PH_RXH: begin
        drv    = 1'b0;
        tick_d = tick_step;
        if (half_end) begin
          shift_d = shift_rx;
          bit_d   = bit_inc;
          if (bit_inc >= 4'd8) begin
            bit_d   = '0;
            last_d  = shift_rx;
            phase_d = PH_NKL;
          end else begin
            phase_d = PH_RXL;
          end
        end
      end
      PH_NKL: begin
        scl    = 1'b0;
        tick_d = tick_step;
        if (half_end) phase_d = PH_NKH;
      end
      PH_NKH: begin
        tick_d = tick_step;
        if (half_end) phase_d = PH_SPL;
      end
      PH_SPL: begin
        scl    = 1'b0;
        sda    = 1'b0;
        tick_d = tick_step;
        if (half_end) phase_d = PH_SPA;
      end
      PH_SPA: begin
        sda    = 1'b0;
        tick_d = tick_step;
        if (half_end) phase_d = PH_SPB;
      end
      PH_SPB: begin
        tick_d = tick_step;
        if (half_end) begin
          if (ack_c != '0) begin
            ack_d   = '0;
            phase_d = PH_STA;
          end else if (!kind_d && (cfg_i.write_cycle_ticks != '0)) begin
            phase_d = PH_HOLD;
          end else begin
            done    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
      end
      PH_HOLD: begin
        tick_d = hold_end ? '0 : tick_inc[23:0];
        if (hold_end) begin
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
    busy = done || (phase_d != PH_IDLE);
  end

  // Hold sequencer state and the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      stage_q     <= STG_DEV_W;
      tick_q      <= '0;
      ack_q       <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      kind_q      <= 1'b0;
      addr_q      <= '0;
      data_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (pop) begin
        phase_q <= phase_d;
        stage_q <= stage_d;
        tick_q  <= tick_d;
        ack_q   <= ack_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        kind_q  <= kind_d;
        addr_q  <= addr_d;
        data_q  <= data_d;
        last_q  <= last_d;
        scl_q   <= scl;
        sda_q   <= sda;
        drv_q   <= drv;
        busy_q  <= busy;
        done_q  <= done;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = scl_q;
  assign sda_level_o = sda_q;
  assign sda_drive_o = drv_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign read_byte_o = last_q;

  // Idle leaves no timer, bit or ACK residue behind
  `I2CM_ASSERT(idle_clean_a, clk_i, rst_ni,
    (phase_q == PH_IDLE) |-> (tick_q == '0 && bit_q == '0 && ack_q == '0))
  // Write cycle hold only follows a write
  `I2CM_ASSERT(hold_write_only_a, clk_i, rst_ni, (phase_q == PH_HOLD) |-> !kind_q)
  // A word waiting at a stalled output is never overwritten
  `I2CM_ASSERT_NEVER(no_overwrite_a, clk_i, rst_ni, out_valid_q && out_stall_i && pop)
  // A popped tick always yields an output word
  `I2CM_ASSERT(pop_gives_word_a, clk_i, rst_ni, pop |=> (out_valid_q && (!done_q || busy_q)))

endmodule

>>> rtl/core/i2c_eeprom_byte_access_master.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master
// Single-byte EEPROM write and random read over I2C, one tick word per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is one timebase tick: request/func/mem_address/write_data
//   start a transaction when the master is idle, sda_sample is the SDA level
//   seen on that tick. Each tick yields exactly one output word with the SCL
//   and SDA levels to drive, the SDA drive enable, busy, a one-tick done and
//   the last byte read.
//   Both channels are valid/stall; the config port (valid/ready, index, data)
//   is always ready. The user must write it only while no transaction runs;
//   the block itself does not enforce this. The tick queue (two entries)
//   feeds a sequencer that registers its state per popped word, so one tick
//   word enters and one result leaves per cycle while out_stall_i stays low.
//   An accepted word is held in a queue slot, then in the output register.
//   When the receiver stalls, the output word holds, the sequencer stops and
//   the queue fills; in_stall_o rises once both queue slots are taken.
//   Reset: sequencer idle, queue empty, registers at their defaults (half bit
//   5, ACK timeout 500, write cycle 10000, device address 0x50).
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_access_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data_i,
  // Tick input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          request_i,
  input  logic                          func_i,
  input  logic [7:0]                    mem_address_i,
  input  logic [7:0]                    write_data_i,
  input  logic                          sda_sample_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          scl_level_o,
  output logic                          sda_level_o,
  output logic                          sda_drive_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic [7:0]                    read_byte_o
);

  i2cm_pkg::cfg_t  cfg_q;
  i2cm_pkg::head_t head;
  logic            pop;
  logic            cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks    <= i2cm_pkg::HalfBitReset;
      cfg_q.ack_timeout_ticks <= i2cm_pkg::AckTimeoutReset;
      cfg_q.write_cycle_ticks <= i2cm_pkg::WriteCycleReset;
      cfg_q.device_address    <= i2cm_pkg::DeviceAddrReset;
    end else if (cfg_we) begin
      unique case (i2cm_pkg::cfg_reg_e'(cfg_index_i))
        i2cm_pkg::CFG_HALF_BIT:    cfg_q.half_bit_ticks    <= cfg_data_i[15:0];
        i2cm_pkg::CFG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks <= cfg_data_i[15:0];
        i2cm_pkg::CFG_WRITE_CYCLE: cfg_q.write_cycle_ticks <= cfg_data_i[23:0];
        i2cm_pkg::CFG_DEVICE_ADDR: cfg_q.device_address    <= cfg_data_i[6:0];
        default:                   cfg_q                   <= cfg_q;
      endcase
    end
  end

  // Front: accept and queue tick words
  i2cm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .request_i     (request_i),
    .func_i        (func_i),
    .mem_address_i (mem_address_i),
    .write_data_i  (write_data_i),
    .sda_sample_i  (sda_sample_i),
    .head_o        (head),
    .pop_i         (pop)
  );

  // Back: bit sequencer with output register
  i2cm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scl_level_o (scl_level_o),
    .sda_level_o (sda_level_o),
    .sda_drive_o (sda_drive_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .read_byte_o (read_byte_o)
  );

endmodule
